FILE: rtl/core/drs_pkg.sv
// shared constants and command codes for the degree rank sorter
package drs_pkg;

    localparam int DEF_MAX_NODES   = 1024;
    localparam int DEF_DEGREE_BITS = 32;

    localparam int CMD_W    = 2;
    localparam int DEG_IN_W = 32;
    localparam int NODE_W   = 10;
    localparam int RANK_W   = 10;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

endpackage

FILE: rtl/core/drs_cell.sv
// one cell of the rank chain: stored degree, compare against the key, pass the count on
module drs_cell #(
    parameter int MAX_NODES   = drs_pkg::DEF_MAX_NODES,
    parameter int DEGREE_BITS = drs_pkg::DEF_DEGREE_BITS,
    parameter int INDEX       = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load_en,
    input  logic [DEGREE_BITS-1:0]           load_degree,
    input  logic [$clog2(MAX_NODES+1)-1:0]   loaded_count,
    input  logic [DEGREE_BITS-1:0]           key_degree,
    input  logic [$clog2(MAX_NODES)-1:0]     key_node,
    input  logic                             descending,
    input  logic                             tok_valid_in,
    input  logic [$clog2(MAX_NODES+1)-1:0]   tok_count_in,
    output logic                             tok_valid_out,
    output logic [$clog2(MAX_NODES+1)-1:0]   tok_count_out
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES);

    logic [DEGREE_BITS-1:0] degree_reg;
    logic                   tok_valid_reg;
    logic [CW-1:0]          tok_count_reg;
    logic                   occupied;
    logic                   sorts_ahead;
    logic                   inc;

    assign occupied = CW'(INDEX) < loaded_count;

    always_comb begin
        if (degree_reg == key_degree) begin
            sorts_ahead = AW'(INDEX) < key_node;
        end else if (descending) begin
            sorts_ahead = degree_reg > key_degree;
        end else begin
            sorts_ahead = degree_reg < key_degree;
        end
        inc = occupied && sorts_ahead;
    end

    always_ff @(posedge aclk) begin
        if (load_en && (loaded_count == CW'(INDEX))) begin
            degree_reg <= load_degree;
        end
        tok_count_reg <= tok_count_in + CW'(inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_in;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_count_out = tok_count_reg;

endmodule

FILE: rtl/core/degree_rank_sorter_core.sv
// top level of the degree rank sorter: command decode, degree memory and cell chain
//
// Commands arrive on the s_ stream, command in s_tuser. Clear empties the set,
// load appends the next node's degree (node number = arrival order), read
// returns the rank of one node on the m_ stream. Ordering is by degree,
// descending or ascending per the register on the cfg_ channel, ties by
// smaller node number. Clear and load finish without leaving the idle state.
// A read of a loaded node fetches its degree from the degree memory, then a
// token walks the chain of MAX_NODES cells, one cell per cycle, each cell
// adding one when its node sorts ahead; the count out of the last cell is the
// rank. A read of an unloaded node gives rank 0 and valid_res 0.
// One command is in work at a time.
// A finished result waits in the output register while the next command is
// taken; a second result waits until the receiver takes the first.
// Loads beyond MAX_NODES are dropped and set the sticky overflow bit.
// Reset empties the set, clears overflow and sets descending order; no
// clearing pass is needed.
module degree_rank_sorter_core #(
    parameter int MAX_NODES   = drs_pkg::DEF_MAX_NODES,
    parameter int DEGREE_BITS = drs_pkg::DEF_DEGREE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [drs_pkg::S_DATA_W-1:0]  s_tdata,  // degree, node, zero pad
    input  logic [drs_pkg::CMD_W-1:0]     s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [drs_pkg::M_DATA_W-1:0]  m_tdata,  // rank, valid_res, overflow, zero pad
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int AW = $clog2(MAX_NODES);
    localparam int RW = drs_pkg::RANK_W;
    localparam int NW = drs_pkg::NODE_W;
    localparam int DIW = drs_pkg::DEG_IN_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [CW-1:0]          count_reg;
    logic                   ovf_reg;
    logic                   desc_reg;
    logic [DEGREE_BITS-1:0] degree_mem [MAX_NODES];
    logic [DEGREE_BITS-1:0] key_reg;
    logic [AW-1:0]          key_node_reg;
    logic [RW-1:0]          pend_rank_reg;
    logic                   pend_valid_reg;
    logic                   pend_ovf_reg;
    logic                   m_tvalid_reg;
    logic [RW-1:0]          out_rank_reg;
    logic                   out_valid_reg;
    logic                   out_ovf_reg;

    logic                   s_fire;
    logic [drs_pkg::CMD_W-1:0] cmd;
    logic [DEGREE_BITS-1:0] in_degree;
    logic [NW-1:0]          in_node;
    logic                   is_full;
    logic                   load_en;
    logic                   read_hit;
    logic                   out_free;
    logic                   tok_v [MAX_NODES+1];
    logic [CW-1:0]          tok_c [MAX_NODES+1];

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign cmd       = s_tuser;
    assign in_degree = DEGREE_BITS'(s_tdata[DIW-1:0]);
    assign in_node   = s_tdata[DIW+NW-1:DIW];
    assign is_full   = count_reg == CW'(MAX_NODES);
    assign load_en   = s_fire && (cmd == drs_pkg::CMD_LOAD) && !is_full;
    assign read_hit  = 32'(in_node) < 32'(count_reg);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (cmd == drs_pkg::CMD_READ)) begin
                    state_next = read_hit ? ST_FETCH : ST_HOLD;
                end
            end
            ST_FETCH: state_next = ST_RUN;
            ST_RUN: begin
                if (tok_v[MAX_NODES]) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            desc_reg     <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                desc_reg <= cfg_data;
            end
            if (s_fire && (cmd == drs_pkg::CMD_CLEAR)) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (s_fire && (cmd == drs_pkg::CMD_LOAD)) begin
                if (is_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if ((state_reg == ST_HOLD) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            degree_mem[count_reg[AW-1:0]] <= in_degree;
        end
        if (s_fire && (cmd == drs_pkg::CMD_READ)) begin
            key_reg      <= degree_mem[AW'(in_node)];
            key_node_reg <= AW'(in_node);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (cmd == drs_pkg::CMD_READ)) begin
            pend_rank_reg  <= '0;
            pend_valid_reg <= 1'b0;
            pend_ovf_reg   <= ovf_reg;
        end else if ((state_reg == ST_RUN) && tok_v[MAX_NODES]) begin
            pend_rank_reg  <= RW'(tok_c[MAX_NODES]);
            pend_valid_reg <= 1'b1;
        end
        if ((state_reg == ST_HOLD) && out_free) begin
            out_rank_reg  <= pend_rank_reg;
            out_valid_reg <= pend_valid_reg;
            out_ovf_reg   <= pend_ovf_reg;
        end
    end

    assign tok_v[0] = state_reg == ST_FETCH;
    assign tok_c[0] = '0;

    for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
        drs_cell #(
            .MAX_NODES   (MAX_NODES),
            .DEGREE_BITS (DEGREE_BITS),
            .INDEX       (k)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .load_en       (load_en),
            .load_degree   (in_degree),
            .loaded_count  (count_reg),
            .key_degree    (key_reg),
            .key_node      (key_node_reg),
            .descending    (desc_reg),
            .tok_valid_in  (tok_v[k]),
            .tok_count_in  (tok_c[k]),
            .tok_valid_out (tok_v[k+1]),
            .tok_count_out (tok_c[k+1])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(drs_pkg::M_DATA_W - RW - 2){1'b0}},
                       out_ovf_reg, out_valid_reg, out_rank_reg};

    // the rank token leaves the chain only during a chain pass
    a_tok_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_v[MAX_NODES] |-> (state_reg == ST_RUN))
        else $error("rank token left the chain outside a pass");

    // the set never grows past its capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_NODES))
        else $error("loaded count beyond capacity");

    // overflow only rises after a load into a full set
    a_ovf_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> $past(s_fire && (cmd == drs_pkg::CMD_LOAD) && is_full))
        else $error("overflow raised without a dropped load");

    // a read of an unloaded node goes straight to the result hold
    a_miss_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (cmd == drs_pkg::CMD_READ) && !read_hit) |=> (state_reg == ST_HOLD))
        else $error("unloaded read did not go to hold");

    // a chain pass produces a rank below the loaded count
    a_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RUN) && tok_v[MAX_NODES]) |-> (tok_c[MAX_NODES] < count_reg))
        else $error("rank not below loaded count");

endmodule

FILE: dv/drs_rank_checker.sv
// rank checker for the degree rank sorter: watches the channels, predicts read results, compares
`timescale 1ns / 1ps
module drs_rank_checker #(
    parameter int MAX_NODES   = drs_pkg::DEF_MAX_NODES,
    parameter int DEGREE_BITS = drs_pkg::DEF_DEGREE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [drs_pkg::S_DATA_W-1:0]  s_tdata,  // degree, node, zero pad
    input  logic [drs_pkg::CMD_W-1:0]     s_tuser,  // command
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [drs_pkg::M_DATA_W-1:0]  m_tdata,  // rank, valid_res, overflow, zero pad
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_data,
    output int                            fail_count,
    output int                            pending
);

    localparam int RANK_W   = drs_pkg::RANK_W;
    localparam int NODE_LSB = drs_pkg::DEG_IN_W;
    localparam logic [63:0] DEG_MASK =
        (DEGREE_BITS >= 64) ? '1 : ((64'd1 << DEGREE_BITS) - 64'd1);

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              valid_res;
        logic              overflow;
    } read_result_t;

    logic [63:0]  degree_store [MAX_NODES];
    int unsigned  node_count;
    logic         overflow_seen;
    logic         order_desc;
    read_result_t expected_reads [$];

    task automatic report_failure(input string msg);
        if (fail_count < 200) begin
            $display("%0t ns: %s", $time, msg);
        end
        fail_count++;
    endtask

    // sort position: loaded nodes ahead by degree, ties go to the smaller node number
    function automatic read_result_t rank_of(input int unsigned node);
        read_result_t res;
        logic [63:0]  own_deg;
        logic [63:0]  other_deg;
        int unsigned  ahead;
        res          = '0;
        ahead        = 0;
        res.overflow = overflow_seen;
        if (node < node_count) begin
            res.valid_res = 1'b1;
            own_deg       = degree_store[node];
            for (int unsigned j = 0; j < node_count; j++) begin
                other_deg = degree_store[j];
                if (j != node) begin
                    if (other_deg == own_deg) begin
                        if (j < node) ahead++;
                    end else if (order_desc ? (other_deg > own_deg) : (other_deg < own_deg)) begin
                        ahead++;
                    end
                end
            end
            res.rank = ahead[RANK_W-1:0];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        read_result_t want;
        if (!aresetn) begin
            fail_count    = 0;
            node_count    = 0;
            overflow_seen = 1'b0;
            order_desc    = 1'b1;
            expected_reads.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_reads.size() == 0) begin
                    report_failure($sformatf("result transaction with no read pending: %h",
                                             m_tdata));
                end else begin
                    want = expected_reads.pop_front();
                    if (m_tdata[RANK_W-1:0] !== want.rank) begin
                        report_failure($sformatf("rank: expected %0d, got %0d",
                                                 want.rank, m_tdata[RANK_W-1:0]));
                    end
                    if (m_tdata[RANK_W] !== want.valid_res) begin
                        report_failure($sformatf("valid_res: expected %0b, got %0b",
                                                 want.valid_res, m_tdata[RANK_W]));
                    end
                    if (m_tdata[RANK_W+1] !== want.overflow) begin
                        report_failure($sformatf("overflow: expected %0b, got %0b",
                                                 want.overflow, m_tdata[RANK_W+1]));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                order_desc = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    drs_pkg::CMD_CLEAR: begin
                        node_count    = 0;
                        overflow_seen = 1'b0;
                    end
                    drs_pkg::CMD_LOAD: begin
                        if (node_count >= MAX_NODES) begin
                            overflow_seen = 1'b1;
                        end else begin
                            degree_store[node_count] =
                                64'(s_tdata[drs_pkg::DEG_IN_W-1:0]) & DEG_MASK;
                            node_count++;
                        end
                    end
                    drs_pkg::CMD_READ: begin
                        want           = rank_of(32'(s_tdata[NODE_LSB +: drs_pkg::NODE_W]));
                        expected_reads = {expected_reads, want};
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending <= expected_reads.size();
    end

endmodule

FILE: dv/tb_top.sv
// testbench top for the degree rank sorter: clock, reset, stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;

    localparam int CMD_W    = drs_pkg::CMD_W;
    localparam int S_DATA_W = drs_pkg::S_DATA_W;
    localparam int M_DATA_W = drs_pkg::M_DATA_W;
    localparam int NODE_W   = drs_pkg::NODE_W;
    localparam int DEG_IN_W = drs_pkg::DEG_IN_W;
    localparam int MAX_N    = drs_pkg::DEF_MAX_NODES;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 8 * (MAX_N + 32);
    localparam int RANDOM_ITEMS   = 750;
    localparam int PAD_W          = S_DATA_W - NODE_W - DEG_IN_W;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;  // degree, node, zero pad
    logic [CMD_W-1:0]    s_tuser   = drs_pkg::CMD_CLEAR;  // command
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;  // rank, valid_res, overflow, zero pad
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b0;

    int          fail_count;
    int          pending;
    bit          idle_on      = 1'b1;
    int unsigned loaded       = 0;
    int unsigned quiet_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    degree_rank_sorter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    drs_rank_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: stall drawn per transaction, often held until the result shows up
    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                @(posedge aclk);
                while (!m_tvalid) @(posedge aclk);
                repeat (stall - 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    function automatic logic [DEG_IN_W-1:0] random_degree();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return DEG_IN_W'($urandom_range(0, 7));
            default: return DEG_IN_W'($urandom());
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] random_node();
        return NODE_W'($urandom_range(0, (1 << NODE_W) - 1));
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DEG_IN_W-1:0] deg,
                             input logic [NODE_W-1:0] node);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, node, deg};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == drs_pkg::CMD_CLEAR) begin
            loaded = 0;
        end else if (cmd == drs_pkg::CMD_LOAD && loaded < MAX_N) begin
            loaded++;
        end
    endtask

    // hold off until every read has been answered and the block has settled
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_order(input logic desc);
        cfg_valid <= 1'b1;
        cfg_data  <= desc;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic read_somewhere();
        if (loaded != 0 && $urandom_range(0, 3) != 0) begin
            send_item(drs_pkg::CMD_READ, random_degree(),
                      NODE_W'($urandom_range(0, loaded - 1)));
        end else begin
            send_item(drs_pkg::CMD_READ, random_degree(), random_node());
        end
    endtask

    initial begin
        logic [DEG_IN_W-1:0] corner_degrees [6];
        int unsigned         random_items;
        int unsigned         phase;
        int unsigned         set_size;
        int unsigned         op_count;
        int unsigned         pick;

        corner_degrees = '{'1, '0, 5, 5, '1, 32'h8000_0000};
        random_items   = 0;
        phase          = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty set, corner degrees with ties, both orders, unused code, clear
        write_order(1'b1);
        send_item(drs_pkg::CMD_READ, '1, '0);
        foreach (corner_degrees[i]) begin
            send_item(drs_pkg::CMD_LOAD, corner_degrees[i], random_node());
        end
        for (int i = 0; i < 6; i++) send_item(drs_pkg::CMD_READ, random_degree(), NODE_W'(i));
        send_item(drs_pkg::CMD_READ, random_degree(), NODE_W'(6));
        send_item(drs_pkg::CMD_READ, '0, '1);
        send_item(CMD_UNUSED, random_degree(), random_node());
        drain();
        write_order(1'b0);
        for (int i = 0; i < 6; i++) send_item(drs_pkg::CMD_READ, random_degree(), NODE_W'(i));
        send_item(drs_pkg::CMD_CLEAR, random_degree(), random_node());
        send_item(drs_pkg::CMD_READ, random_degree(), '0);

        while (random_items < RANDOM_ITEMS) begin
            drain();
            idle_on = ($urandom_range(0, 3) != 0);
            write_order(phase == 3 ? 1'b1 : 1'($urandom_range(0, 1)));

            // full set, loads past capacity, first and last ranks in both orders
            if (phase == 3) begin
                send_item(drs_pkg::CMD_CLEAR, random_degree(), random_node());
                send_item(drs_pkg::CMD_LOAD, '1, random_node());
                repeat (MAX_N - 2) begin
                    send_item(drs_pkg::CMD_LOAD, DEG_IN_W'($urandom_range(1, 4095)),
                              random_node());
                end
                send_item(drs_pkg::CMD_LOAD, '0, random_node());
                repeat (3) send_item(drs_pkg::CMD_LOAD, random_degree(), random_node());
                send_item(drs_pkg::CMD_READ, random_degree(), '1);
                send_item(drs_pkg::CMD_READ, random_degree(), '0);
                repeat (10) send_item(drs_pkg::CMD_READ, random_degree(), random_node());
                drain();
                write_order(1'b0);
                send_item(drs_pkg::CMD_READ, random_degree(), '1);
                send_item(drs_pkg::CMD_READ, random_degree(), '0);
                repeat (8) send_item(drs_pkg::CMD_READ, random_degree(), random_node());
                send_item(drs_pkg::CMD_CLEAR, random_degree(), random_node());
                send_item(drs_pkg::CMD_READ, random_degree(), '0);
                random_items += MAX_N + 28;
            end

            set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
            op_count = $urandom_range(4, 12);
            send_item(drs_pkg::CMD_CLEAR, random_degree(), random_node());
            repeat (set_size) send_item(drs_pkg::CMD_LOAD, random_degree(), random_node());
            repeat (op_count) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    read_somewhere();
                end else if (pick < 17) begin
                    send_item(drs_pkg::CMD_LOAD, random_degree(), random_node());
                end else if (pick < 19) begin
                    send_item(CMD_UNUSED, random_degree(), random_node());
                end else begin
                    send_item(drs_pkg::CMD_CLEAR, random_degree(), random_node());
                end
            end
            random_items += 1 + set_size + op_count;
            phase++;
        end

        drain();
        repeat (MAX_N + 16) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
